// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- src/cts_pkg.sv -----
package cts_pkg;

    typedef enum logic [1:0] {
        MODE_SKIP    = 2'd0,
        MODE_QUOTED  = 2'd1,
        MODE_PLAIN   = 2'd2,
        MODE_DISCARD = 2'd3
    } mode_t;

    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0d;

    typedef struct packed {
        logic       valid;
        logic       char_valid;
        logic [7:0] out_char;
        logic       token_end;
        logic [7:0] token_length;
        logic       no_token;
    } cts_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

endpackage

// ----- src/cts_cfg.sv -----
module cts_cfg
    import cts_pkg::*;
#(
    parameter int unsigned MAX_TOKEN = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [8:0] cfg_data,
    output logic [7:0] keep_limit
);

    // the stored count never goes past 255, so sizes above 256 all act alike
    localparam int unsigned CAP_TOP     = (MAX_TOKEN > 256) ? 256 : MAX_TOKEN;
    localparam logic [8:0]  CAP_TOP_W   = 9'(CAP_TOP);
    localparam logic [7:0]  RESET_LIMIT = 8'(CAP_TOP - 1);

    logic [7:0] limit_reg;
    logic [7:0] limit_next;

    always_comb
    begin
        if (cfg_data == 9'd0)
        begin
            limit_next = 8'd0;
        end
        else if (cfg_data > CAP_TOP_W)
        begin
            limit_next = RESET_LIMIT;
        end
        else
        begin
            limit_next = 8'(cfg_data - 9'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= RESET_LIMIT;
        end
        else if (cfg_valid)
        begin
            limit_reg <= limit_next;
        end
    end

    assign keep_limit = limit_reg;

endmodule

// ----- src/cts_step.sv -----
`include "assert_macros.svh"
module cts_step
    import cts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic [7:0]  ch,
    input  logic        end_of_stream,
    input  logic [7:0]  keep_limit,
    output cts_result_t res
);

    mode_t      mode_reg,  mode_next;
    logic       dq_reg,    dq_next;
    logic [7:0] count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SKIP;
            dq_reg    <= 1'b0;
            count_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            mode_reg  <= mode_next;
            dq_reg    <= dq_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        logic [7:0] close_q;
        logic       room;
        close_q    = dq_reg ? CH_DQUOTE : CH_SQUOTE;
        room       = (count_reg < keep_limit);
        mode_next  = mode_reg;
        dq_next    = dq_reg;
        count_next = count_reg;
        res        = '0;

        unique case (mode_reg)
            MODE_SKIP:
            begin
                if (end_of_stream)
                begin
                    res.valid    = 1'b1;
                    res.no_token = 1'b1;
                end
                else if (!is_space(ch))
                begin
                    count_next = 8'd0;
                    if ((ch == CH_SQUOTE) || (ch == CH_DQUOTE))
                    begin
                        dq_next   = (ch == CH_DQUOTE);
                        mode_next = MODE_QUOTED;
                    end
                    else if (ch == CH_COMMA)
                    begin
                        // empty token
                        res.valid     = 1'b1;
                        res.token_end = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_PLAIN;
                        if (keep_limit != 8'd0)
                        begin
                            count_next     = 8'd1;
                            res.valid      = 1'b1;
                            res.char_valid = 1'b1;
                            res.out_char   = ch;
                        end
                    end
                end
            end
            MODE_QUOTED:
            begin
                if (end_of_stream)
                begin
                    res.valid        = 1'b1;
                    res.token_end    = 1'b1;
                    res.token_length = count_reg;
                    mode_next        = MODE_SKIP;
                end
                else
                begin
                    if (room)
                    begin
                        count_next     = count_reg + 8'd1;
                        res.valid      = 1'b1;
                        res.char_valid = 1'b1;
                        res.out_char   = ch;
                    end
                    // closing quote is kept when there is room, and ends the token in one result
                    if (ch == close_q)
                    begin
                        res.valid        = 1'b1;
                        res.token_end    = 1'b1;
                        res.token_length = count_next;
                        mode_next        = MODE_DISCARD;
                    end
                end
            end
            MODE_PLAIN:
            begin
                if (end_of_stream || (ch == CH_COMMA) || (ch == CH_NEWLINE))
                begin
                    res.valid        = 1'b1;
                    res.token_end    = 1'b1;
                    res.token_length = count_reg;
                    mode_next        = MODE_SKIP;
                end
                else if (is_space(ch))
                begin
                    res.valid        = 1'b1;
                    res.token_end    = 1'b1;
                    res.token_length = count_reg;
                    mode_next        = MODE_DISCARD;
                end
                else if (room)
                begin
                    count_next     = count_reg + 8'd1;
                    res.valid      = 1'b1;
                    res.char_valid = 1'b1;
                    res.out_char   = ch;
                end
            end
            MODE_DISCARD:
            begin
                if (end_of_stream || (ch == CH_COMMA))
                begin
                    mode_next = MODE_SKIP;
                end
            end
            default:
            begin
                mode_next = MODE_SKIP;
            end
        endcase
    end

    `ASSERT_CLK(a_eos_to_skip, clk, rst_n, (in_fire && end_of_stream) |=> (mode_reg == MODE_SKIP))
    `ASSERT_NEVER(a_discard_silent, clk, rst_n, (mode_reg == MODE_DISCARD) && res.valid)
    `ASSERT_NEVER(a_no_token_alone, clk, rst_n, res.no_token && (res.char_valid || res.token_end))

endmodule

// ----- src/cts_out_reg.sv -----
`include "assert_macros.svh"
module cts_out_reg
    import cts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  cts_result_t res,
    input  logic        out_stall,
    output logic        in_stall,
    output logic        out_valid,
    output cts_result_t out_res
);

    logic        valid_reg;
    logic        valid_next;
    cts_result_t res_reg;

    // hold off input only while a result sits here and the sink is stalling
    assign in_stall = valid_reg && out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        if (in_fire && res.valid)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res.valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    `ASSERT_CLK(a_stall_needs_hold, clk, rst_n, in_stall |-> valid_reg)
    `ASSERT_CLK(a_new_result_shown, clk, rst_n, (in_fire && res.valid) |=> valid_reg)

endmodule

// ----- src/comma_token_splitter_core.sv -----
// comma-delimited token splitter. one byte (or end-of-stream mark) is taken per
// transaction and at most one result follows, registered in the cycle after the
// input transaction. the block sustains one input transaction per cycle; input
// stall is raised only while a result is held in the output register and
// out_stall is high. max_token_len is written through the cfg port (always
// ready) and is clamped to MAX_TOKEN and a stored count of 255 at write time.
module comma_token_splitter_core
    import cts_pkg::*;
#(
    parameter int unsigned MAX_TOKEN = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] ch,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       char_valid,
    output logic [7:0] out_char,
    output logic       token_end,
    output logic [7:0] token_length,
    output logic       no_token
);

    logic        in_fire;
    logic [7:0]  keep_limit;
    cts_result_t step_res;
    cts_result_t out_res;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !in_stall;

    cts_cfg #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .keep_limit (keep_limit)
    );

    cts_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .ch            (ch),
        .end_of_stream (end_of_stream),
        .keep_limit    (keep_limit),
        .res           (step_res)
    );

    cts_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .res       (step_res),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign char_valid   = out_res.char_valid;
    assign out_char     = out_res.out_char;
    assign token_end    = out_res.token_end;
    assign token_length = out_res.token_length;
    assign no_token     = out_res.no_token;

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam int unsigned TOKEN_BUF   = 256;
    localparam int unsigned HOLD_CYCLES = 80;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } stream_item_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       token_end;
        logic [7:0] token_length;
        logic       no_token;
    } token_res_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [8:0] cfg_data      = '0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [7:0] ch            = '0;
    logic       end_of_stream = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic       char_valid;
    logic [7:0] out_char;
    logic       token_end;
    logic [7:0] token_length;
    logic       no_token;

    comma_token_splitter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ch            (ch),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .char_valid    (char_valid),
        .out_char      (out_char),
        .token_end     (token_end),
        .token_length  (token_length),
        .no_token      (no_token)
    );

    // splitter state as predicted
    mode_t      tok_mode  = MODE_SKIP;
    logic       dq_open   = 1'b0;
    logic [7:0] tok_count = '0;
    logic [8:0] tok_size  = 9'd256;

    stream_item_t stream_q[$];
    token_res_t   due_results[$];
    int unsigned  pushed_cnt    = 0;
    int unsigned  accepted_cnt  = 0;
    int unsigned  errors        = 0;
    bit           in_taken      = 1'b0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    bit           hold_req      = 1'b0;
    bit           hold_taken    = 1'b0;
    int unsigned  hold_left     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit blank_byte(input logic [7:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic [7:0] keep_cap(input logic [8:0] sz);
        int unsigned c;
        c = sz;
        if (c > TOKEN_BUF) c = TOKEN_BUF;
        if (c == 0) c = 1;
        return 8'(c - 1);
    endfunction

    function automatic bit take_char(input logic [7:0] c, inout token_res_t r);
        if (tok_count >= keep_cap(tok_size)) return 1'b0;
        tok_count++;
        r.char_valid = 1'b1;
        r.out_char   = c;
        return 1'b1;
    endfunction

    function automatic void close_token(inout token_res_t r);
        r.token_end    = 1'b1;
        r.token_length = tok_count;
    endfunction

    // one transaction through the splitter, returns 1 when a result follows
    function automatic bit split_step(input stream_item_t it, output token_res_t r);
        bit hit;
        logic [7:0] q;
        r   = '0;
        hit = 1'b0;
        case (tok_mode)
            MODE_SKIP:
            begin
                if (it.eos) begin
                    r.no_token = 1'b1;
                    hit = 1'b1;
                end else if (!blank_byte(it.ch)) begin
                    tok_count = '0;
                    if (it.ch == CH_SQUOTE || it.ch == CH_DQUOTE) begin
                        dq_open  = (it.ch == CH_DQUOTE);
                        tok_mode = MODE_QUOTED;
                    end else if (it.ch == CH_COMMA) begin
                        close_token(r);
                        hit = 1'b1;
                    end else begin
                        tok_mode = MODE_PLAIN;
                        hit = take_char(it.ch, r);
                    end
                end
            end
            MODE_QUOTED:
            begin
                if (it.eos) begin
                    close_token(r);
                    tok_mode = MODE_SKIP;
                    hit = 1'b1;
                end else begin
                    q = dq_open ? CH_DQUOTE : CH_SQUOTE;
                    hit = take_char(it.ch, r);
                    // closing quote is kept when there is room, then strict-comma discard
                    if (it.ch == q) begin
                        close_token(r);
                        tok_mode = MODE_DISCARD;
                        hit = 1'b1;
                    end
                end
            end
            MODE_PLAIN:
            begin
                if (it.eos || it.ch == CH_COMMA || it.ch == CH_NEWLINE) begin
                    close_token(r);
                    tok_mode = MODE_SKIP;
                    hit = 1'b1;
                end else if (blank_byte(it.ch)) begin
                    close_token(r);
                    tok_mode = MODE_DISCARD;
                    hit = 1'b1;
                end else begin
                    hit = take_char(it.ch, r);
                end
            end
            default:
            begin
                if (it.eos || it.ch == CH_COMMA) tok_mode = MODE_SKIP;
            end
        endcase
        return hit;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    function automatic void feed(input logic [7:0] c, input bit eos = 1'b0);
        stream_item_t it;
        it.ch  = c;
        it.eos = eos;
        stream_q.push_back(it);
        pushed_cnt++;
    endfunction

    function automatic void feed_eos();
        feed(8'($urandom_range(255)), 1'b1);
    endfunction

    function automatic void feed_text(input string s);
        for (int i = 0; i < s.len(); i++) feed(s[i]);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(126, 33));
        while (c == CH_COMMA || c == CH_DQUOTE || c == CH_SQUOTE);
        return c;
    endfunction

    function automatic logic [7:0] blank_pick();
        int unsigned k;
        k = $urandom_range(8);
        return (k >= 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] quoted_char(input logic [7:0] q);
        logic [7:0] c;
        do c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(126, 32));
        while (c == q);
        return c;
    endfunction

    // mostly well-formed fields with random content, some noise and broken quotes
    function automatic void make_stream(input int unsigned n);
        int unsigned stop;
        int unsigned kind;
        int unsigned len;
        logic [7:0] q;
        stop = pushed_cnt + n;
        while (pushed_cnt < stop) begin
            if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) feed(blank_pick());
            kind = $urandom_range(99);
            len  = ($urandom_range(4) == 0) ? $urandom_range(40, 12) : $urandom_range(8);
            if (kind < 6) begin
                feed_eos();
            end else if (kind < 14) begin
                repeat ($urandom_range(3, 1)) feed(8'($urandom_range(255)));
            end else if (kind < 20) begin
                feed($urandom_range(1) ? CH_COMMA : CH_NEWLINE);
            end else begin
                if (kind < 60) begin
                    repeat (len) feed(text_char());
                end else begin
                    q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                    feed(q);
                    repeat (len) feed(quoted_char(q));
                    if ($urandom_range(9) != 0) feed(q);
                end
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: feed(CH_COMMA);
                    5, 6:          feed(CH_NEWLINE);
                    7:
                    begin
                        feed(blank_pick());
                        repeat ($urandom_range(2)) feed(text_char());
                        feed(CH_COMMA);
                    end
                    8:             feed_eos();
                    default:       ;
                endcase
            end
        end
    endfunction

    task automatic set_token_size(input logic [8:0] size, input int unsigned s_idle,
                                  input int unsigned r_idle);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = size;
        do @(posedge clk); while (!cfg_ready);
        tok_size      = size;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        @(negedge clk);
        cfg_valid = 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (accepted_cnt != pushed_cnt || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        stream_item_t nxt;
        if (!in_valid || in_taken) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = stream_q.pop_front();
                ch            <= nxt.ch;
                end_of_stream <= nxt.eos;
                in_valid      <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall, with one long hold-off to back up the input
    always @(negedge clk)
    begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: check results, then predict from the accepted input transaction
    always @(posedge clk)
    begin
        token_res_t seen;
        token_res_t want;
        stream_item_t cur;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                seen = {char_valid, out_char, token_end, token_length, no_token};
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, seen);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("char_valid", want.char_valid, seen.char_valid);
                    check_field("out_char", want.out_char, seen.out_char);
                    check_field("token_end", want.token_end, seen.token_end);
                    check_field("token_length", want.token_length, seen.token_length);
                    check_field("no_token", want.no_token, seen.no_token);
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken) begin
                cur.ch  = ch;
                cur.eos = end_of_stream;
                accepted_cnt++;
                if (split_step(cur, want)) due_results.push_back(want);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_token_size(9'd256, 37, 49);
        feed_eos();
        feed(8'h00);
        feed(8'hff);
        feed(CH_COMMA);
        feed_text("  ,");
        feed_text("\"a'\"z,");
        feed_text("'b");
        feed_eos();
        feed_text("c\tq");
        feed_eos();
        feed_text("d\n");
        feed_text("e");
        feed_eos();
        feed_eos();
        wait_idle();

        set_token_size(9'd1, 37, 49);
        make_stream(90);
        wait_idle();
        set_token_size(9'd0, 37, 49);
        make_stream(90);
        wait_idle();

        set_token_size(9'd511, 49, 37);
        make_stream(90);
        // quoted token longer than the 255-character cap
        feed(CH_DQUOTE);
        repeat (270) feed(text_char());
        feed(CH_DQUOTE);
        feed(CH_COMMA);
        wait_idle();
        set_token_size(9'd5, 49, 37);
        make_stream(90);
        wait_idle();

        set_token_size(9'd2, 0, 0);
        make_stream(90);
        hold_req = 1'b1;
        wait_idle();
        set_token_size(9'd17, 0, 0);
        make_stream(90);
        wait_idle();
        set_token_size(9'd300, 0, 0);
        make_stream(90);
        wait_idle();

        repeat (10) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && due_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
